[rtl/ved_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ved_pkg
// Shared codes, character constants and types of the visible escape decoder.
// ----------------------------------------------------------------------------
package ved_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int PH_W   = 3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [PH_W-1:0]   t_phase;

    // Decoder phases
    localparam t_phase PH_IDLE  = 3'd0;
    localparam t_phase PH_CARET = 3'd1;
    localparam t_phase PH_BSL   = 3'd2;
    localparam t_phase PH_DIG1  = 3'd3;
    localparam t_phase PH_DIG2  = 3'd4;

    // Result kinds
    localparam t_kind KIND_BYTE  = 2'd0;
    localparam t_kind KIND_END   = 2'd1;
    localparam t_kind KIND_BAD   = 2'd2;
    localparam t_kind KIND_TRUNC = 2'd3;

    // Character constants
    localparam t_byte CH_NL    = 8'h0A;
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_DEL   = 8'h7F;
    localparam t_byte CH_ESC   = 8'h1B;
    localparam t_byte CH_BS    = 8'h08;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_CARET = 8'h5E;
    localparam t_byte CH_BSL   = 8'h5C;
    localparam t_byte CH_AT    = 8'h40;
    localparam t_byte CH_USCORE = 8'h5F;
    localparam t_byte CH_QUEST = 8'h3F;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_NINE  = 8'h39;
    localparam t_byte CH_UP_E  = 8'h45;
    localparam t_byte CH_LO_B  = 8'h62;
    localparam t_byte CH_LO_R  = 8'h72;
    localparam t_byte CH_LO_N  = 8'h6E;
    localparam t_byte CH_LO_T  = 8'h74;
    localparam t_byte CH_LO_S  = 8'h73;

    // One result item with its valid flag
    typedef struct packed {
        logic  vld;
        t_kind kind;
        t_byte value;
    } t_res;

    // Decoder state
    typedef struct packed {
        t_phase phase;
        t_byte  partial;
    } t_state;

endpackage
`default_nettype wire

[rtl/ved_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ved_in_if
// Input channel: one escaped byte or an end marker per item.
// ----------------------------------------------------------------------------
interface ved_in_if;
    logic                  valid;
    logic                  ready;
    logic [ved_pkg::BYTE_W-1:0] in_byte;
    logic                  end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface
`default_nettype wire

[rtl/ved_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ved_out_if
// Output channel: one decoded byte, end or error report per item.
// ----------------------------------------------------------------------------
interface ved_out_if;
    logic                       valid;
    logic                       ready;
    logic [ved_pkg::KIND_W-1:0] kind;
    logic [ved_pkg::BYTE_W-1:0] out_value;

    modport source (output valid, output kind, output out_value, input ready);
    modport sink   (input valid, input kind, input out_value, output ready);
endinterface
`default_nettype wire

[rtl/ved_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ved_decode
// Next-state and result logic for one byte of the escaped stream.
// ----------------------------------------------------------------------------
module ved_decode (
    input  ved_pkg::t_state i_state,
    input  ved_pkg::t_byte  i_byte,
    input  logic            i_eos,
    output ved_pkg::t_state o_state,
    output ved_pkg::t_res   o_res
);
    import ved_pkg::*;

    logic       w_digit;
    logic [3:0] w_dval;
    t_byte      w_dsum;

    // Digit detect and value
    assign w_digit = (i_byte inside {[CH_ZERO:CH_NINE]});
    assign w_dval  = 4'(i_byte - CH_ZERO);

    always_comb begin
        w_dsum = i_state.partial + {4'b0, w_dval};
        o_state = i_state;
        o_state.phase = PH_IDLE;
        o_res = '{vld: 1'b1, kind: KIND_BAD, value: i_byte};

        if (i_eos) begin
            // End marker: clean end in idle, truncation otherwise
            o_state.partial = '0;
            o_res.value = '0;
            o_res.kind = (i_state.phase == PH_IDLE) ? KIND_END : KIND_TRUNC;
        end else begin
            case (i_state.phase)
                PH_CARET: begin
                    if (i_byte == CH_QUEST) begin
                        o_res = '{vld: 1'b1, kind: KIND_BYTE, value: CH_DEL};
                    end else if (i_byte inside {[CH_AT:CH_USCORE]}) begin
                        o_res = '{vld: 1'b1, kind: KIND_BYTE, value: i_byte - CH_AT};
                    end
                end
                PH_BSL: begin
                    o_res.kind = KIND_BYTE;
                    case (i_byte)
                        CH_BSL:   o_res.value = CH_BSL;
                        CH_CARET: o_res.value = CH_CARET;
                        CH_UP_E:  o_res.value = CH_ESC;
                        CH_LO_B:  o_res.value = CH_BS;
                        CH_LO_R:  o_res.value = CH_CR;
                        CH_LO_N:  o_res.value = CH_NL;
                        CH_LO_T:  o_res.value = CH_TAB;
                        CH_LO_S:  o_res.value = CH_SPACE;
                        default: begin
                            if (w_digit) begin
                                // First octal-style digit lands in the top two bits
                                o_res.vld = 1'b0;
                                o_state.phase = PH_DIG1;
                                o_state.partial = {w_dval[1:0], 6'b0};
                            end else begin
                                o_res.kind = KIND_BAD;
                            end
                        end
                    endcase
                end
                PH_DIG1: begin
                    if (w_digit) begin
                        o_res.vld = 1'b0;
                        o_state.phase = PH_DIG2;
                        o_state.partial = i_state.partial + {1'b0, w_dval, 3'b0};
                    end else begin
                        o_state.partial = '0;
                    end
                end
                PH_DIG2: begin
                    o_state.partial = '0;
                    if (w_digit) begin
                        o_res.kind = KIND_BYTE;
                        o_res.value = w_dsum;
                    end
                end
                default: begin
                    // Idle, and unused phase codes
                    if (i_byte == CH_NL) begin
                        o_res.vld = 1'b0;
                    end else if (i_byte < CH_SPACE || i_byte >= CH_DEL) begin
                        o_res.kind = KIND_BAD;
                    end else if (i_byte == CH_CARET) begin
                        o_res.vld = 1'b0;
                        o_state.phase = PH_CARET;
                    end else if (i_byte == CH_BSL) begin
                        o_res.vld = 1'b0;
                        o_state.phase = PH_BSL;
                    end else begin
                        o_res.kind = KIND_BYTE;
                    end
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/ved_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ved_out_reg
// Result register that drives the output channel.
// ----------------------------------------------------------------------------
module ved_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  ved_pkg::t_res i_res,
    output logic          o_can_load,
    ved_out_if.source     o_out_ch
);
    import ved_pkg::*;

    logic  r_vld;
    t_kind r_kind;
    t_byte r_value;

    // Free when empty or being taken this cycle
    assign o_can_load = !r_vld || o_out_ch.ready;

    // Hold valid until the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_can_load) begin
            r_vld <= i_load;
        end
    end

    // Capture payload on load
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_kind  <= i_res.kind;
            r_value <= i_res.value;
        end
    end

    assign o_out_ch.valid     = r_vld;
    assign o_out_ch.kind      = r_kind;
    assign o_out_ch.out_value = r_value;
endmodule
`default_nettype wire

[rtl/visible_escape_decoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Order: input register, decode logic, then the output result register.
// Throughput: one item per cycle; the input register, decode logic and the
// result register form a two-stage path that advances whenever the result
// register is empty or being taken.
// Reset: synchronous, active low; clears both valid flags, phase to idle and
// the digit sum to zero.
// ----------------------------------------------------------------------------
// visible_escape_decoder_top
// Decodes a caret/backslash escaped byte stream back into raw bytes.
// ----------------------------------------------------------------------------
module visible_escape_decoder_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ved_in_if.sink   i_in_ch,
    ved_out_if.source o_out_ch
);
    import ved_pkg::*;

    logic   r_in_vld;
    t_byte  r_in_byte;
    logic   r_in_eos;
    t_state r_state;
    t_state n_state;
    t_res   w_res;
    logic   w_can_load;
    logic   w_fire;

    // Advance the input stage when the result register can take its output
    assign w_fire        = r_in_vld && w_can_load;
    assign i_in_ch.ready = !r_in_vld || w_can_load;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_vld <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in_byte <= i_in_ch.in_byte;
            r_in_eos  <= i_in_ch.end_of_stream;
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, partial: '0};
        end else if (w_fire) begin
            r_state <= n_state;
        end
    end

    ved_decode u_decode (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_eos   (r_in_eos),
        .o_state (n_state),
        .o_res   (w_res)
    );

    ved_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_fire && w_res.vld),
        .i_res      (w_res),
        .o_can_load (w_can_load),
        .o_out_ch   (o_out_ch)
    );
endmodule
`default_nettype wire

[rtl/ved_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ved_checker
// Port-level checks of the visible escape decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ved_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    ved_in_if.sink    i_in_ch,
    ved_out_if.source o_out_ch
);
    import ved_pkg::*;

    // Output is empty right after reset
    ap_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_ch.valid)
        else $error("output valid after reset");

    // Stalled result holds
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && !o_out_ch.ready |=>
            o_out_ch.valid && $stable(o_out_ch.kind) && $stable(o_out_ch.out_value))
        else $error("stalled result changed");

    // End and truncation reports carry a zero value
    ap_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_ch.valid && (o_out_ch.kind == KIND_END || o_out_ch.kind == KIND_TRUNC)
            |-> o_out_ch.out_value == '0)
        else $error("end report with nonzero value");

    // A fresh result follows an item accepted into the input register
    ap_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_ch.valid) |-> $past(i_in_ch.valid && i_in_ch.ready, 2))
        else $error("result without accepted item");
endmodule

bind visible_escape_decoder_top ved_checker u_ved_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_in_ch  (i_in_ch),
    .o_out_ch (o_out_ch)
);
`default_nettype wire
